/* sv/gebq_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gebq_pkg
// Shared types and constants of the cascaded biquad graphic equalizer.
// ----------------------------------------------------------------------------
package gebq_pkg;

    // field widths
    localparam int KIND_W   = 2;
    localparam int BAND_W   = 5;
    localparam int SEL_W    = 3;
    localparam int SAMPLE_W = 24;
    localparam int COEF_W   = 32;
    localparam int GAIN_W   = 24;
    localparam int HIST_W   = 48;

    // configuration port
    localparam int APB_AW = 3;
    localparam int APB_DW = 32;
    localparam logic REG_ENABLE = 1'b0;
    localparam logic REG_PREAMP = 1'b1;

    localparam logic [GAIN_W-1:0] GAIN_RESET = 24'd1048576;

    // item kinds
    localparam logic [KIND_W-1:0] KIND_SAMPLE = 2'd0;
    localparam logic [KIND_W-1:0] KIND_COEF   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd2;

    // coefficient order in a section; also the issue slot of each product
    typedef logic [SEL_W-1:0] slot_t;
    localparam slot_t SLOT_B0 = 3'd0;
    localparam slot_t SLOT_B1 = 3'd1;
    localparam slot_t SLOT_B2 = 3'd2;
    localparam slot_t SLOT_A1 = 3'd3;
    localparam slot_t SLOT_A2 = 3'd4;
    localparam slot_t NUM_COEFS = 3'd5;

    localparam logic signed [COEF_W-1:0] COEF_ONE = 32'sh1000_0000;

    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 24'sh7F_FFFF;
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 24'sh80_0000;

    localparam logic signed [63:0] MAX48 = 64'sh0000_7FFF_FFFF_FFFF;
    localparam logic signed [63:0] MIN48 = -64'sh0000_8000_0000_0000;

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_CLEAR,
        ST_MUL,
        ST_PRE,
        ST_RUN,
        ST_TAIL0,
        ST_TAIL1,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic  coef_sweep_we;
        logic  hist_sweep_we;
        logic  sweep_b0;
        logic  coef_item_we;
        logic  take_sample;
        logic  pre_mul;
        logic  pre_start;
        logic  run;
        slot_t slot;
        logic  wb;
        logic  load_out;
        logic  bypass;
    } cmd_t;

    function automatic logic signed [HIST_W-1:0] sat48(input logic signed [63:0] v);
        logic signed [HIST_W-1:0] r;
        if (v > MAX48) begin
            r = MAX48[HIST_W-1:0];
        end
        else if (v < MIN48) begin
            r = MIN48[HIST_W-1:0];
        end
        else begin
            r = v[HIST_W-1:0];
        end
        return r;
    endfunction

endpackage
`default_nettype wire

/* sv/cascaded_biquad_graphic_equalizer.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cascaded_biquad_graphic_equalizer
// Preamp and BANDS transposed direct form II biquads in series, per channel
// history, one shared two-stage multiplier issuing one product per cycle.
// ----------------------------------------------------------------------------
// Each section takes five products through the single multiplier. The input is not
//   ready again until the previous sample has been loaded into the output register;
//   a sample taken while disabled skips the sections and passes through unchanged.
// Reset: after rst_n rises, an init sweep loads identity coefficients and zero history
//   before the first item is accepted.
module cascaded_biquad_graphic_equalizer #(
    parameter int BANDS    = 31,
    parameter int CHANNELS = 2
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  psel,
    input  wire logic                                  penable,
    input  wire logic                                  pwrite,
    input  wire logic [gebq_pkg::APB_AW-1:0]           paddr,
    input  wire logic [gebq_pkg::APB_DW-1:0]           pwdata,
    output logic [gebq_pkg::APB_DW-1:0]                prdata,
    output logic                                       pready,
    input  wire logic                                  in_valid,
    output logic                                       in_ready,
    input  wire logic [gebq_pkg::KIND_W-1:0]           kind,
    input  wire logic                                  channel,
    input  wire logic signed [gebq_pkg::SAMPLE_W-1:0]  sample_in,
    input  wire logic [gebq_pkg::BAND_W-1:0]           band,
    input  wire logic [gebq_pkg::SEL_W-1:0]            coef_select,
    input  wire logic signed [gebq_pkg::COEF_W-1:0]    coef_value,
    output logic                                       out_valid,
    input  wire logic                                  out_ready,
    output logic                                       channel_out,
    output logic signed [gebq_pkg::SAMPLE_W-1:0]       sample_out,
    output logic                                       clipped
);

    localparam int NCOEF     = BANDS * 5;
    localparam int NHIST     = BANDS * CHANNELS;
    localparam int SWEEP_LEN = (NCOEF > NHIST) ? NCOEF : NHIST;
    localparam int SWA       = $clog2(SWEEP_LEN);

    logic                          enable_reg;
    logic [gebq_pkg::GAIN_W-1:0]   gain_reg;
    logic                          cfg_wr;
    gebq_pkg::cmd_t                cmd;
    logic [SWA-1:0]                sweep_addr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg <= 1'b1;
            gain_reg   <= gebq_pkg::GAIN_RESET;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[2])
                gebq_pkg::REG_ENABLE: enable_reg <= pwdata[0];
                gebq_pkg::REG_PREAMP: gain_reg   <= pwdata[gebq_pkg::GAIN_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            gebq_pkg::REG_ENABLE: prdata = gebq_pkg::APB_DW'(enable_reg);
            gebq_pkg::REG_PREAMP: prdata = gebq_pkg::APB_DW'(gain_reg);
            default:              prdata = '0;
        endcase
    end

    gebq_ctrl #(
        .BANDS    (BANDS),
        .CHANNELS (CHANNELS)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .kind        (kind),
        .channel     (channel),
        .band        (band),
        .coef_select (coef_select),
        .enable      (enable_reg),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .cmd         (cmd),
        .sweep_addr  (sweep_addr)
    );

    gebq_dp #(
        .BANDS    (BANDS),
        .CHANNELS (CHANNELS)
    ) u_dp (
        .clk         (clk),
        .cmd         (cmd),
        .sweep_addr  (sweep_addr),
        .gain        (gain_reg),
        .channel     (channel),
        .sample_in   (sample_in),
        .band        (band),
        .coef_select (coef_select),
        .coef_value  (coef_value),
        .channel_out (channel_out),
        .sample_out  (sample_out),
        .clipped     (clipped)
    );

endmodule
`default_nettype wire

/* sv/gebq_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gebq_ctrl
// Sequencer: memory sweeps, item decode and the five-slot section schedule.
// ----------------------------------------------------------------------------
module gebq_ctrl #(
    parameter int BANDS    = 31,
    parameter int CHANNELS = 2
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [gebq_pkg::KIND_W-1:0]   kind,
    input  wire logic                          channel,
    input  wire logic [gebq_pkg::BAND_W-1:0]   band,
    input  wire logic [gebq_pkg::SEL_W-1:0]    coef_select,
    input  wire logic                          enable,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output gebq_pkg::cmd_t                     cmd,
    output logic [$clog2(((BANDS*5) > (BANDS*CHANNELS)) ? (BANDS*5)
                         : (BANDS*CHANNELS))-1:0] sweep_addr
);

    localparam int NCOEF     = BANDS * 5;
    localparam int NHIST     = BANDS * CHANNELS;
    localparam int SWEEP_LEN = (NCOEF > NHIST) ? NCOEF : NHIST;
    localparam int SWA       = $clog2(SWEEP_LEN);
    localparam int BW        = (BANDS > 1) ? $clog2(BANDS) : 1;

    gebq_pkg::state_t      state_reg, state_next;
    logic [SWA-1:0]        sweep_idx_reg, sweep_idx_next;
    gebq_pkg::slot_t       coef_sel_reg, coef_sel_next;
    gebq_pkg::slot_t       slot_reg, slot_next;
    logic [BW-1:0]         band_reg, band_next;
    logic                  bypass_reg, bypass_next;
    logic                  out_valid_reg, out_valid_next;

    logic init_last, clear_last, run_last, ch_ok, coef_ok;

    assign init_last  = (sweep_idx_reg == SWA'(SWEEP_LEN - 1));
    assign clear_last = (sweep_idx_reg == SWA'(NHIST - 1));
    assign run_last   = (slot_reg == gebq_pkg::SLOT_A2) && (band_reg == BW'(BANDS - 1));
    assign ch_ok      = (32'(channel) < CHANNELS);
    assign coef_ok    = (32'(band) < BANDS) && (coef_select < gebq_pkg::NUM_COEFS);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            gebq_pkg::ST_INIT:
            begin
                if (init_last)
                begin
                    state_next = gebq_pkg::ST_IDLE;
                end
            end
            gebq_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    case (kind)
                        gebq_pkg::KIND_SAMPLE:
                        begin
                            if (ch_ok)
                            begin
                                state_next = enable ? gebq_pkg::ST_MUL : gebq_pkg::ST_FINISH;
                            end
                        end
                        gebq_pkg::KIND_CLEAR: state_next = gebq_pkg::ST_CLEAR;
                        default:              state_next = gebq_pkg::ST_IDLE;
                    endcase
                end
            end
            gebq_pkg::ST_CLEAR:
            begin
                if (clear_last)
                begin
                    state_next = gebq_pkg::ST_IDLE;
                end
            end
            gebq_pkg::ST_MUL:   state_next = gebq_pkg::ST_PRE;
            gebq_pkg::ST_PRE:   state_next = gebq_pkg::ST_RUN;
            gebq_pkg::ST_RUN:
            begin
                if (run_last)
                begin
                    state_next = gebq_pkg::ST_TAIL0;
                end
            end
            gebq_pkg::ST_TAIL0: state_next = gebq_pkg::ST_TAIL1;
            gebq_pkg::ST_TAIL1: state_next = gebq_pkg::ST_FINISH;
            gebq_pkg::ST_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    state_next = gebq_pkg::ST_IDLE;
                end
            end
            default:            state_next = gebq_pkg::ST_INIT;
        endcase
    end

    // outputs
    always_comb
    begin
        cmd        = '0;
        cmd.bypass = bypass_reg;
        in_ready   = 1'b0;
        unique case (state_reg)
            gebq_pkg::ST_INIT:
            begin
                cmd.coef_sweep_we = (32'(sweep_idx_reg) < NCOEF);
                cmd.hist_sweep_we = (32'(sweep_idx_reg) < NHIST);
                cmd.sweep_b0      = (coef_sel_reg == gebq_pkg::SLOT_B0);
            end
            gebq_pkg::ST_IDLE:
            begin
                in_ready         = 1'b1;
                cmd.coef_item_we = in_valid && (kind == gebq_pkg::KIND_COEF) && coef_ok;
                cmd.take_sample  = in_valid && (kind == gebq_pkg::KIND_SAMPLE) && ch_ok;
            end
            gebq_pkg::ST_CLEAR:
            begin
                cmd.hist_sweep_we = 1'b1;
            end
            gebq_pkg::ST_MUL:   cmd.pre_mul   = 1'b1;
            gebq_pkg::ST_PRE:   cmd.pre_start = 1'b1;
            gebq_pkg::ST_RUN:
            begin
                cmd.run  = 1'b1;
                cmd.slot = slot_reg;
                // first band has no previous section to write back
                cmd.wb   = (band_reg != '0);
            end
            gebq_pkg::ST_TAIL0:
            begin
                cmd.slot = gebq_pkg::SLOT_B0;
                cmd.wb   = 1'b1;
            end
            gebq_pkg::ST_TAIL1:
            begin
                cmd.slot = gebq_pkg::SLOT_B1;
                cmd.wb   = 1'b1;
            end
            gebq_pkg::ST_FINISH:
            begin
                cmd.load_out = !out_valid_reg || out_ready;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    // counters and flags
    always_comb
    begin
        sweep_idx_next = sweep_idx_reg;
        coef_sel_next  = coef_sel_reg;
        slot_next      = slot_reg;
        band_next      = band_reg;
        bypass_next    = bypass_reg;
        out_valid_next = out_valid_reg;

        if (state_reg == gebq_pkg::ST_INIT)
        begin
            sweep_idx_next = init_last ? '0 : sweep_idx_reg + SWA'(1);
            coef_sel_next  = (coef_sel_reg == gebq_pkg::SLOT_A2) ? gebq_pkg::SLOT_B0
                             : coef_sel_reg + 3'd1;
        end
        if (state_reg == gebq_pkg::ST_CLEAR)
        begin
            sweep_idx_next = clear_last ? '0 : sweep_idx_reg + SWA'(1);
        end
        if (state_reg == gebq_pkg::ST_PRE)
        begin
            slot_next = gebq_pkg::SLOT_B0;
            band_next = '0;
        end
        if (state_reg == gebq_pkg::ST_RUN)
        begin
            if (slot_reg == gebq_pkg::SLOT_A2)
            begin
                slot_next = gebq_pkg::SLOT_B0;
                band_next = band_reg + BW'(1);
            end
            else
            begin
                slot_next = slot_reg + 3'd1;
            end
        end
        if (cmd.take_sample)
        begin
            bypass_next = !enable;
        end
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= gebq_pkg::ST_INIT;
            sweep_idx_reg <= '0;
            coef_sel_reg  <= gebq_pkg::SLOT_B0;
            slot_reg      <= gebq_pkg::SLOT_B0;
            band_reg      <= '0;
            bypass_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sweep_idx_reg <= sweep_idx_next;
            coef_sel_reg  <= coef_sel_next;
            slot_reg      <= slot_next;
            band_reg      <= band_next;
            bypass_reg    <= bypass_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign sweep_addr = sweep_idx_reg;

endmodule
`default_nettype wire

/* sv/gebq_cmul.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gebq_cmul
// Two-stage coefficient multiplier: round(c * v / 2^28), saturated to 48 bits.
// The 48-bit operand is split in two 24-bit halves.
// ----------------------------------------------------------------------------
module gebq_cmul (
    input  wire logic                                  clk,
    input  wire logic signed [gebq_pkg::COEF_W-1:0]    coef,
    input  wire logic signed [gebq_pkg::HIST_W-1:0]    operand,
    output logic signed [gebq_pkg::HIST_W-1:0]         product
);

    logic signed [56:0] plo_next, plo_reg;
    logic signed [55:0] phi_next, phi_reg;
    logic signed [57:0] lo_rnd;
    logic signed [33:0] lo_q;
    logic signed [56:0] sum;
    logic signed [52:0] sum_sh;
    logic signed [gebq_pkg::HIST_W-1:0] product_reg;

    assign plo_next = coef * $signed({1'b0, operand[23:0]});
    assign phi_next = coef * $signed(operand[47:24]);

    assign lo_rnd = 58'(plo_reg) + 58'sd134217728;
    assign lo_q   = lo_rnd[57:24];
    assign sum    = 57'(phi_reg) + 57'(lo_q);
    assign sum_sh = sum[56:4];

    always_ff @(posedge clk)
    begin
        plo_reg     <= plo_next;
        phi_reg     <= phi_next;
        product_reg <= gebq_pkg::sat48(64'(sum_sh));
    end

    assign product = product_reg;

endmodule
`default_nettype wire

/* sv/gebq_dp.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gebq_dp
// Datapath: coefficient and history memories, preamp, section arithmetic
// and the output stage.
// ----------------------------------------------------------------------------
module gebq_dp #(
    parameter int BANDS    = 31,
    parameter int CHANNELS = 2
) (
    input  wire logic                                      clk,
    input  wire gebq_pkg::cmd_t                            cmd,
    input  wire logic [$clog2(((BANDS*5) > (BANDS*CHANNELS)) ? (BANDS*5)
                              : (BANDS*CHANNELS))-1:0]     sweep_addr,
    input  wire logic [gebq_pkg::GAIN_W-1:0]               gain,
    input  wire logic                                      channel,
    input  wire logic signed [gebq_pkg::SAMPLE_W-1:0]      sample_in,
    input  wire logic [gebq_pkg::BAND_W-1:0]               band,
    input  wire logic [gebq_pkg::SEL_W-1:0]                coef_select,
    input  wire logic signed [gebq_pkg::COEF_W-1:0]        coef_value,
    output logic                                           channel_out,
    output logic signed [gebq_pkg::SAMPLE_W-1:0]           sample_out,
    output logic                                           clipped
);

    localparam int NCOEF = BANDS * 5;
    localparam int NHIST = BANDS * CHANNELS;
    localparam int CAW   = $clog2(NCOEF);
    localparam int HAW   = (NHIST > 1) ? $clog2(NHIST) : 1;
    localparam int IAW   = gebq_pkg::BAND_W + 4;

    logic signed [gebq_pkg::COEF_W-1:0] coef_mem [NCOEF];
    logic signed [gebq_pkg::HIST_W-1:0] hf_mem [NHIST];
    logic signed [gebq_pkg::HIST_W-1:0] hs_mem [NHIST];

    logic signed [gebq_pkg::COEF_W-1:0]   coef_q;
    logic signed [gebq_pkg::HIST_W-1:0]   hf_q, hs_q;
    logic signed [gebq_pkg::SAMPLE_W-1:0] sample_reg;
    logic                                 ch_reg;
    logic signed [48:0]                   prod_reg, prod_next;
    logic signed [gebq_pkg::HIST_W-1:0]   x_reg, pb1_reg, pb2_reg;
    logic [CAW:0]                         ptr_reg;
    logic [HAW-1:0]                       hrd_reg, hwr_reg;
    logic                                 channel_out_reg, clipped_reg;
    logic signed [gebq_pkg::SAMPLE_W-1:0] sample_out_reg;

    logic [IAW-1:0]                       item_full;
    logic [CAW-1:0]                       item_addr, rd_addr;
    logic                                 rd_en;
    logic signed [49:0]                   pre_t;
    logic signed [46:0]                   pre_x;
    logic signed [gebq_pkg::HIST_W-1:0]   prod_r, y_sat, s1_new, s2_new;
    logic                                 hf_we, hs_we;
    logic [HAW-1:0]                       h_waddr;
    logic signed [48:0]                   out_t;
    logic signed [31:0]                   out_r;
    logic signed [gebq_pkg::SAMPLE_W-1:0] out_sat;
    logic                                 out_clip;

    gebq_cmul u_cmul (
        .clk     (clk),
        .coef    (coef_q),
        .operand (x_reg),
        .product (prod_r)
    );

    // band*5 + select
    assign item_full = (IAW'(band) << 2) + IAW'(band) + IAW'(coef_select);
    assign item_addr = CAW'(item_full);

    assign rd_addr = cmd.pre_start ? '0 : ptr_reg[CAW-1:0];
    assign rd_en   = cmd.pre_start || (cmd.run && (32'(ptr_reg) < NCOEF));

    assign prod_next = sample_reg * $signed({1'b0, gain});
    assign pre_t     = 50'(prod_reg) + 50'sd4;
    assign pre_x     = pre_t[49:3];

    // results of the shared multiplier are registered in it and consumed in a later slot
    assign y_sat  = gebq_pkg::sat48(64'(prod_r) + 64'(hf_q));
    assign s1_new = gebq_pkg::sat48(64'(pb1_reg) - 64'(prod_r) + 64'(hs_q));
    assign s2_new = gebq_pkg::sat48(64'(pb2_reg) - 64'(prod_r));

    assign hf_we   = cmd.hist_sweep_we || (cmd.wb && (cmd.slot == gebq_pkg::SLOT_B0));
    assign hs_we   = cmd.hist_sweep_we || (cmd.wb && (cmd.slot == gebq_pkg::SLOT_B1));
    assign h_waddr = cmd.hist_sweep_we ? sweep_addr[HAW-1:0] : hwr_reg;

    assign out_t = 49'(x_reg) + 49'sd65536;
    assign out_r = out_t[48:17];

    always_comb
    begin
        out_sat  = out_r[gebq_pkg::SAMPLE_W-1:0];
        out_clip = 1'b0;
        if (out_r > 32'(gebq_pkg::SAMPLE_MAX))
        begin
            out_sat  = gebq_pkg::SAMPLE_MAX;
            out_clip = 1'b1;
        end
        else if (out_r < 32'(gebq_pkg::SAMPLE_MIN))
        begin
            out_sat  = gebq_pkg::SAMPLE_MIN;
            out_clip = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.coef_sweep_we)
        begin
            coef_mem[sweep_addr[CAW-1:0]] <= cmd.sweep_b0 ? gebq_pkg::COEF_ONE : '0;
        end
        else if (cmd.coef_item_we)
        begin
            coef_mem[item_addr] <= coef_value;
        end
        if (rd_en)
        begin
            coef_q <= coef_mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (hf_we)
        begin
            hf_mem[h_waddr] <= cmd.hist_sweep_we ? '0 : s1_new;
        end
        if (cmd.run && (cmd.slot == gebq_pkg::SLOT_B1))
        begin
            hf_q <= hf_mem[hrd_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (hs_we)
        begin
            hs_mem[h_waddr] <= cmd.hist_sweep_we ? '0 : s2_new;
        end
        if (cmd.run && (cmd.slot == gebq_pkg::SLOT_A2))
        begin
            hs_q <= hs_mem[hrd_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take_sample)
        begin
            sample_reg <= sample_in;
            ch_reg     <= channel;
        end
        if (cmd.pre_mul)
        begin
            prod_reg <= prod_next;
        end
        if (cmd.pre_start)
        begin
            x_reg   <= 48'(pre_x);
            ptr_reg <= (CAW + 1)'(1);
            hrd_reg <= HAW'(ch_reg);
        end
        if (cmd.run)
        begin
            ptr_reg <= ptr_reg + (CAW + 1)'(1);
            case (cmd.slot)
                gebq_pkg::SLOT_B2: x_reg   <= y_sat;
                gebq_pkg::SLOT_A1: pb1_reg <= prod_r;
                gebq_pkg::SLOT_A2:
                begin
                    pb2_reg <= prod_r;
                    hwr_reg <= hrd_reg;
                    hrd_reg <= hrd_reg + HAW'(CHANNELS);
                end
                default:
                begin
                end
            endcase
        end
        if (cmd.load_out)
        begin
            channel_out_reg <= ch_reg;
            sample_out_reg  <= cmd.bypass ? sample_reg : out_sat;
            clipped_reg     <= cmd.bypass ? 1'b0 : out_clip;
        end
    end

    assign channel_out = channel_out_reg;
    assign sample_out  = sample_out_reg;
    assign clipped     = clipped_reg;

endmodule
`default_nettype wire

/* sv/gebq_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gebq_checker
// Port-level checks of the equalizer, bound to the top level.
// ----------------------------------------------------------------------------
module gebq_checker #(
    parameter int CHANNELS = 2
) (
    input wire logic                                  clk,
    input wire logic                                  rst_n,
    input wire logic                                  in_valid,
    input wire logic                                  in_ready,
    input wire logic [gebq_pkg::KIND_W-1:0]           kind,
    input wire logic                                  channel,
    input wire logic                                  out_valid,
    input wire logic                                  out_ready,
    input wire logic                                  channel_out,
    input wire logic signed [gebq_pkg::SAMPLE_W-1:0]  sample_out,
    input wire logic                                  clipped
);

    // a sample keeps the block busy for at least the next cycle
    a_sample_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (kind == gebq_pkg::KIND_SAMPLE) && (32'(channel) < CHANNELS)
        |=> !in_ready)
        else $error("input still ready right after a sample item");

    // a coefficient write completes in the cycle it is taken
    a_coef_write_quick: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (kind == gebq_pkg::KIND_COEF) |=> in_ready)
        else $error("coefficient write stalled the input");

    a_clip_at_rail: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && clipped
        |-> (sample_out == gebq_pkg::SAMPLE_MAX) || (sample_out == gebq_pkg::SAMPLE_MIN))
        else $error("clipped set on a sample that is not at a rail");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result item dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(sample_out) && $stable(channel_out)
        && $stable(clipped))
        else $error("result item changed while stalled");

endmodule

bind cascaded_biquad_graphic_equalizer gebq_checker #(
    .CHANNELS (CHANNELS)
) u_gebq_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .kind        (kind),
    .channel     (channel),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .channel_out (channel_out),
    .sample_out  (sample_out),
    .clipped     (clipped)
);
`default_nettype wire
